>>> hdl/nearest_point_search_3d_unit_assert.svh
// ----------------------------------------------------------------------------
// nearest point search assertion macros
// concurrent checks on i_clk, quiet while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef NEAREST_POINT_SEARCH_3D_UNIT_ASSERT_SVH
`define NEAREST_POINT_SEARCH_3D_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// condition holds at every edge
`define NPSD_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("npsd check failed");

// consequence in the same cycle
`define NPSD_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("npsd check failed");

// consequence in the next cycle
`define NPSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("npsd check failed");

`else

`define NPSD_ASSERT_ALWAYS(lbl, expr)
`define NPSD_ASSERT_IMPLY(lbl, ante, cons)
`define NPSD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> hdl/npsd_pkg.sv
// ----------------------------------------------------------------------------
// npsd_pkg
// shared types and constants of the nearest point search unit
// ----------------------------------------------------------------------------
`default_nettype none

package npsd_pkg;

    // result queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic                 empty;
        logic [QCNT_BITS-1:0] count;
    } t_queue_stat;

    // square root sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROOT,
        ST_HOLD
    } t_root_state;

endpackage

`default_nettype wire

>>> hdl/npsd_queue.sv
// ----------------------------------------------------------------------------
// npsd_queue
// short first-in first-out queue of finished search words
// ----------------------------------------------------------------------------
`default_nettype none
`include "nearest_point_search_3d_unit_assert.svh"

module npsd_queue #(
    parameter int DATA_BITS = 69
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire logic [DATA_BITS-1:0] i_data,
    input  wire logic                 i_pop,
    output logic      [DATA_BITS-1:0] o_data,
    output npsd_pkg::t_queue_stat     o_stat
);

    logic [DATA_BITS-1:0]           r_mem [npsd_pkg::QUEUE_DEPTH];
    logic [npsd_pkg::QPTR_BITS-1:0] r_wr_ptr;
    logic [npsd_pkg::QPTR_BITS-1:0] r_rd_ptr;
    logic [npsd_pkg::QCNT_BITS-1:0] r_count;
    logic [npsd_pkg::QPTR_BITS-1:0] n_wr_ptr;
    logic [npsd_pkg::QPTR_BITS-1:0] n_rd_ptr;
    logic                           w_pop;

    assign w_pop = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = (r_wr_ptr == npsd_pkg::QPTR_BITS'(npsd_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : r_wr_ptr + npsd_pkg::QPTR_BITS'(1);
        n_rd_ptr = (r_rd_ptr == npsd_pkg::QPTR_BITS'(npsd_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : r_rd_ptr + npsd_pkg::QPTR_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + npsd_pkg::QCNT_BITS'(1);
            end else if (!i_push && w_pop) begin
                r_count <= r_count - npsd_pkg::QCNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // show-ahead read of the oldest word
    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;

    // front reserves room before it accepts a closing item
    `NPSD_ASSERT_IMPLY(a_no_overflow, i_push, r_count < npsd_pkg::QCNT_BITS'(npsd_pkg::QUEUE_DEPTH))
    `NPSD_ASSERT_IMPLY(a_no_underflow, i_pop, r_count != '0)
    `NPSD_ASSERT_NEXT(a_count_track, 1'b1, r_count == $past(r_count) + $past(i_push) - $past(w_pop))

endmodule

`default_nettype wire

>>> hdl/npsd_front.sv
// ----------------------------------------------------------------------------
// npsd_front
// accepts candidates, squares distances and tracks the nearest one
// ----------------------------------------------------------------------------
`default_nettype none

module npsd_front #(
    parameter int COORD_BITS = 24,
    parameter int INDEX_BITS = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_push,
    output logic                                        o_full,
    input  wire logic signed [COORD_BITS-1:0]           i_query_x,
    input  wire logic signed [COORD_BITS-1:0]           i_query_y,
    input  wire logic signed [COORD_BITS-1:0]           i_query_z,
    input  wire logic signed [COORD_BITS-1:0]           i_cand_x,
    input  wire logic signed [COORD_BITS-1:0]           i_cand_y,
    input  wire logic signed [COORD_BITS-1:0]           i_cand_z,
    input  wire logic                                   i_has_candidate,
    input  wire logic                                   i_last_item,
    input  wire npsd_pkg::t_queue_stat                  i_q_stat,
    output logic                                        o_q_push,
    output logic [INDEX_BITS+2*COORD_BITS+4:0]          o_q_data
);

    localparam int MAG_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS = 2 * COORD_BITS + 2;
    localparam int SQ_BITS   = 2 * COORD_BITS + 4;
    localparam int CRD_BITS  = npsd_pkg::QCNT_BITS + 1;

    // search state
    logic                         r_mid;
    logic [INDEX_BITS-1:0]        r_count;
    logic [2:0][COORD_BITS-1:0]   r_held;
    logic [SQ_BITS-1:0]           r_best_sq;
    logic [INDEX_BITS-1:0]        r_best_pos;
    logic                         r_found;

    // pipeline stages
    logic                         r_s1_v, r_s1_c, r_s1_l;
    logic [INDEX_BITS-1:0]        r_s1_pos;
    logic [2:0][MAG_BITS-1:0]     r_s1_mag;
    logic                         r_s2_v, r_s2_c, r_s2_l;
    logic [INDEX_BITS-1:0]        r_s2_pos;
    logic [2:0][PROD_BITS-1:0]    r_s2_prod;
    logic                         r_s3_v, r_s3_c, r_s3_l;
    logic [INDEX_BITS-1:0]        r_s3_pos;
    logic [SQ_BITS-1:0]           r_s3_sq;

    logic                         w_accept;
    logic [CRD_BITS-1:0]          w_credit;
    logic [2:0][COORD_BITS-1:0]   w_query;
    logic [2:0][COORD_BITS-1:0]   w_cand;
    logic [2:0][MAG_BITS-1:0]     w_diff;
    logic [2:0][MAG_BITS-1:0]     w_mag;
    logic [INDEX_BITS-1:0]        w_pos;
    logic [INDEX_BITS-1:0]        n_count;
    logic [SQ_BITS-1:0]           w_sum;
    logic                         w_take;
    logic [SQ_BITS-1:0]           w_fin_sq;
    logic [INDEX_BITS-1:0]        w_fin_pos;
    logic                         w_fin_found;

    // room for every closing word already in flight
    assign w_credit = CRD_BITS'(i_q_stat.count)
                    + CRD_BITS'(r_s1_v & r_s1_l)
                    + CRD_BITS'(r_s2_v & r_s2_l)
                    + CRD_BITS'(r_s3_v & r_s3_l);
    assign o_full   = !i_rst_n || (w_credit >= CRD_BITS'(npsd_pkg::QUEUE_DEPTH));
    assign w_accept = i_push && !o_full;

    assign w_cand = {i_cand_z, i_cand_y, i_cand_x};

    always_comb begin
        // query is taken from the first word of a search
        w_query = r_mid ? r_held : {i_query_z, i_query_y, i_query_x};
        for (int a = 0; a < 3; a++) begin
            w_diff[a] = {w_cand[a][COORD_BITS-1], w_cand[a]}
                      - {w_query[a][COORD_BITS-1], w_query[a]};
            w_mag[a]  = w_diff[a][MAG_BITS-1] ? (~w_diff[a] + MAG_BITS'(1)) : w_diff[a];
        end
        w_pos = r_mid ? r_count : '0;
        if (!i_has_candidate || (&w_pos)) begin
            n_count = w_pos;
        end else begin
            n_count = w_pos + INDEX_BITS'(1);
        end
    end

    always_comb begin
        w_sum = SQ_BITS'(r_s2_prod[0]) + SQ_BITS'(r_s2_prod[1]) + SQ_BITS'(r_s2_prod[2]);
    end

    // strictly nearer replaces, so the first of equals stays
    always_comb begin
        w_take      = r_s3_v && r_s3_c && (r_s3_sq < r_best_sq);
        w_fin_sq    = w_take ? r_s3_sq  : r_best_sq;
        w_fin_pos   = w_take ? r_s3_pos : r_best_pos;
        w_fin_found = w_take || r_found;
    end

    assign o_q_push = r_s3_v && r_s3_l;
    assign o_q_data = {w_fin_found, (w_fin_found ? w_fin_pos : INDEX_BITS'(0)), w_fin_sq};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid      <= 1'b0;
            r_count    <= '0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_s3_v     <= 1'b0;
            r_best_sq  <= '1;
            r_best_pos <= '0;
            r_found    <= 1'b0;
        end else begin
            r_s1_v <= w_accept;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            if (w_accept) begin
                r_mid   <= !i_last_item;
                r_count <= n_count;
            end
            if (o_q_push) begin
                r_best_sq  <= '1;
                r_best_pos <= '0;
                r_found    <= 1'b0;
            end else if (w_take) begin
                r_best_sq  <= r_s3_sq;
                r_best_pos <= r_s3_pos;
                r_found    <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_held <= w_query;
        end
        r_s1_c   <= i_has_candidate;
        r_s1_l   <= i_last_item;
        r_s1_pos <= w_pos;
        r_s1_mag <= w_mag;
        r_s2_c   <= r_s1_c;
        r_s2_l   <= r_s1_l;
        r_s2_pos <= r_s1_pos;
        for (int a = 0; a < 3; a++) begin
            r_s2_prod[a] <= {{MAG_BITS{1'b0}}, r_s1_mag[a]} * {{MAG_BITS{1'b0}}, r_s1_mag[a]};
        end
        r_s3_c   <= r_s2_c;
        r_s3_l   <= r_s2_l;
        r_s3_pos <= r_s2_pos;
        r_s3_sq  <= w_sum;
    end

endmodule

`default_nettype wire

>>> hdl/npsd_root.sv
// ----------------------------------------------------------------------------
// npsd_root
// integer square root of the best square, two bits a cycle, and result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "nearest_point_search_3d_unit_assert.svh"

module npsd_root #(
    parameter int COORD_BITS = 24,
    parameter int INDEX_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic [INDEX_BITS+2*COORD_BITS+4:0]  i_q_data,
    input  wire npsd_pkg::t_queue_stat               i_q_stat,
    output logic                                     o_q_pop,
    output logic                                     o_empty,
    input  wire logic                                i_pop,
    output logic                                     o_found,
    output logic [INDEX_BITS-1:0]                    o_best_index,
    output logic [COORD_BITS+1:0]                    o_best_distance
);

    localparam int SQ_BITS   = 2 * COORD_BITS + 4;
    localparam int ROOT_BITS = COORD_BITS + 2;
    localparam int REM_BITS  = ROOT_BITS + 2;
    localparam int STEP_BITS = $clog2(ROOT_BITS);

    npsd_pkg::t_root_state r_state, n_state;

    logic [SQ_BITS-1:0]    r_val;
    logic [REM_BITS-1:0]   r_rem;
    logic [ROOT_BITS-1:0]  r_root;
    logic [STEP_BITS-1:0]  r_step;
    logic                  r_found;
    logic [INDEX_BITS-1:0] r_index;
    logic                  r_out_valid;
    logic                  r_out_found;
    logic [INDEX_BITS-1:0] r_out_index;
    logic [ROOT_BITS-1:0]  r_out_dist;

    logic                  w_load, w_step, w_emit;
    logic [REM_BITS+1:0]   w_rem_sh;
    logic [REM_BITS+1:0]   w_trial;
    logic [REM_BITS+1:0]   w_diff;
    logic                  w_ge;

    // one restoring step: bring down two bits, try root*4+1
    always_comb begin
        w_rem_sh = {r_rem, r_val[SQ_BITS-1 -: 2]};
        w_trial  = {2'b00, r_root, 2'b01};
        w_ge     = (w_rem_sh >= w_trial);
        w_diff   = w_rem_sh - w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= npsd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_load  = 1'b0;
        w_step  = 1'b0;
        w_emit  = 1'b0;
        unique case (r_state)
            npsd_pkg::ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    w_load  = 1'b1;
                    n_state = npsd_pkg::ST_ROOT;
                end
            end
            npsd_pkg::ST_ROOT: begin
                w_step = 1'b1;
                if (r_step == STEP_BITS'(ROOT_BITS - 1)) begin
                    n_state = npsd_pkg::ST_HOLD;
                end
            end
            npsd_pkg::ST_HOLD: begin
                if (!r_out_valid || i_pop) begin
                    w_emit  = 1'b1;
                    n_state = npsd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = npsd_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_q_pop = w_load;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_val   <= i_q_data[SQ_BITS-1:0];
            r_index <= i_q_data[SQ_BITS +: INDEX_BITS];
            r_found <= i_q_data[SQ_BITS+INDEX_BITS];
            r_rem   <= '0;
            r_root  <= '0;
            r_step  <= '0;
        end else if (w_step) begin
            r_val  <= {r_val[SQ_BITS-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[REM_BITS-1:0] : w_rem_sh[REM_BITS-1:0];
            r_root <= {r_root[ROOT_BITS-2:0], w_ge};
            r_step <= r_step + STEP_BITS'(1);
        end
        if (w_emit) begin
            r_out_found <= r_found;
            r_out_index <= r_index;
            r_out_dist  <= r_found ? r_root : '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_empty         = !r_out_valid;
    assign o_found         = r_out_found;
    assign o_best_index    = r_out_index;
    assign o_best_distance = r_out_dist;

    `NPSD_ASSERT_IMPLY(a_empty_list, r_out_valid && !r_out_found, (r_out_dist == '1) && (r_out_index == '0))

endmodule

`default_nettype wire

>>> hdl/nearest_point_search_3d_unit.sv
// ----------------------------------------------------------------------------
// nearest_point_search_3d_unit
// linear nearest point search over a stream of 3-d candidate positions
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------------
//  input     | push / full        | query_x/y/z, cand_x/y/z, has_candidate,
//            |                    | last_item
//  result    | empty / pop        | found, best_index, best_distance
//
//  the front takes one word per cycle while full is low; a squared distance is
//  compared, and a closing word queued, from stage s3, after stages s1 and s2
//  each search takes the back through load, COORD_BITS+2 root steps of two bits
//  each and hand-off, so closing words that arrive faster than the back finishes
//  them are absorbed by the QUEUE_DEPTH-entry queue and then push full
//  full rises when the queue plus closing words in flight would fill it
//  reset is synchronous active low; full is high while reset is applied
//  a waiting result sits in the output register and stalls the back, then the front
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_point_search_3d_unit #(
    parameter int COORD_BITS = 24,
    parameter int INDEX_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // input words
    input  wire logic                         push,
    output logic                              full,
    input  wire logic signed [COORD_BITS-1:0] i_query_x,
    input  wire logic signed [COORD_BITS-1:0] i_query_y,
    input  wire logic signed [COORD_BITS-1:0] i_query_z,
    input  wire logic signed [COORD_BITS-1:0] i_cand_x,
    input  wire logic signed [COORD_BITS-1:0] i_cand_y,
    input  wire logic signed [COORD_BITS-1:0] i_cand_z,
    input  wire logic                         i_has_candidate,
    input  wire logic                         i_last_item,
    // result words
    output logic                              empty,
    input  wire logic                         pop,
    output logic                              o_found,
    output logic [INDEX_BITS-1:0]             o_best_index,
    output logic [COORD_BITS+1:0]             o_best_distance
);

    // found, index, best square
    localparam int ENTRY_BITS = INDEX_BITS + 2 * COORD_BITS + 5;

    npsd_pkg::t_queue_stat   w_q_stat;
    logic                    w_q_push;
    logic                    w_q_pop;
    logic [ENTRY_BITS-1:0]   w_q_wdata;
    logic [ENTRY_BITS-1:0]   w_q_rdata;

    // front: query latch, distance pipeline, running best per search
    npsd_front #(
        .COORD_BITS (COORD_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_query_x       (i_query_x),
        .i_query_y       (i_query_y),
        .i_query_z       (i_query_z),
        .i_cand_x        (i_cand_x),
        .i_cand_y        (i_cand_y),
        .i_cand_z        (i_cand_z),
        .i_has_candidate (i_has_candidate),
        .i_last_item     (i_last_item),
        .i_q_stat        (w_q_stat),
        .o_q_push        (w_q_push),
        .o_q_data        (w_q_wdata)
    );

    // closed searches waiting for their root
    npsd_queue #(
        .DATA_BITS (ENTRY_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .i_pop   (w_q_pop),
        .o_data  (w_q_rdata),
        .o_stat  (w_q_stat)
    );

    // back: square root and result register
    npsd_root #(
        .COORD_BITS (COORD_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_root (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_data        (w_q_rdata),
        .i_q_stat        (w_q_stat),
        .o_q_pop         (w_q_pop),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_found         (o_found),
        .o_best_index    (o_best_index),
        .o_best_distance (o_best_distance)
    );

endmodule

`default_nettype wire
